FILE: rtl/core/stst_pkg.sv
// Package for the sorted table insert/remove unit.
// Holds the shared types, status and kind codes, and the control state type.
// No dependencies.
package stst_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUTCNT_W = 5;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_COMPARE,
    CTL_COMMIT
  } ctl_state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic compare;   // capture compare flags against the held item
    logic insert;    // apply an insert shift
    logic remove;    // apply a remove shift
  } cell_ctrl_t;

  // Status a cell shows to its neighbors and to the top level.
  typedef struct packed {
    logic used;      // cell holds an entry
    logic gt;        // entry above item, or cell empty
    logic ge;        // cell used and entry at or above item
    logic eq;        // cell used and entry equal to item
  } cell_flags_t;

endpackage

FILE: rtl/core/stst_cell.sv
// One cell of the sorted table chain: one entry, its occupancy and compare flags.
// Depends on stst_pkg.
module stst_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  stst_pkg::cell_ctrl_t ctrl,
  input  stst_pkg::value_t     item,
  input  stst_pkg::value_t     left_entry,
  input  stst_pkg::cell_flags_t left_flags,
  input  stst_pkg::value_t     right_entry,
  input  stst_pkg::cell_flags_t right_flags,
  output stst_pkg::value_t     entry,
  output stst_pkg::cell_flags_t flags
);

  logic used;
  logic gt;
  logic ge;
  logic eq;

  assign flags = '{used: used, gt: gt, ge: ge, eq: eq};

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctrl.insert) begin
      used <= used | left_flags.used;
    end else if (ctrl.remove) begin
      used <= right_flags.used;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      gt <= !used || (entry > item);
      ge <= used && (entry >= item);
      eq <= used && (entry == item);
    end
  end

  // Entries at or past the insert point move up one; past the removed one move down.
  always_ff @(posedge clk) begin
    if (ctrl.insert && gt) begin
      entry <= left_flags.gt ? left_entry : item;
    end else if (ctrl.remove && ge) begin
      entry <= right_entry;
    end
  end

endmodule

FILE: rtl/core/sorted_table_insert_remove_unit.sv
// Sorted table insert/remove unit: a chain of CAPACITY cells kept in ascending order.
// An accepted word is held, compare flags are registered in the compare state, and the
// result is registered in the commit state once the output is free. A new word is taken
// only when idle or at commit, after every cell of the chain has compared and shifted.
// Reset (rst, synchronous): table empty, no result pending, input ready.
// Depends on stst_pkg and stst_cell.
module sorted_table_insert_remove_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] item_value
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] removed_value, [36:32] stored_count, [39:37] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  stst_pkg::ctl_state_t  state;
  stst_pkg::ctl_state_t  state_next;
  stst_pkg::cell_ctrl_t  ctrl;
  stst_pkg::value_t      item;
  stst_pkg::kind_t       kind;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;

  stst_pkg::value_t      entry_w [CAPACITY];
  stst_pkg::cell_flags_t flag_w  [CAPACITY];
  logic [CAPACITY-1:0]   eq_vec;

  logic                  found;
  logic                  full;
  logic                  out_free;
  logic                  accept;
  logic                  commit;
  stst_pkg::status_t     status_next;

  stst_pkg::status_t     status_q;
  stst_pkg::value_t      removed_q;
  logic [stst_pkg::OUTCNT_W-1:0] stored_q;

  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign commit   = (state == stst_pkg::CTL_COMMIT) && out_free;
  assign full     = (count == CNT_W'(CAPACITY));
  assign found    = |eq_vec;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    stst_pkg::value_t      l_entry;
    stst_pkg::cell_flags_t l_flags;
    stst_pkg::value_t      r_entry;
    stst_pkg::cell_flags_t r_flags;

    if (i == 0) begin : g_head
      assign l_entry = '0;
      assign l_flags = '{used: 1'b1, gt: 1'b0, ge: 1'b0, eq: 1'b0};
    end else begin : g_mid
      assign l_entry = entry_w[i-1];
      assign l_flags = flag_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_entry = '0;
      assign r_flags = '{used: 1'b0, gt: 1'b1, ge: 1'b0, eq: 1'b0};
    end else begin : g_body
      assign r_entry = entry_w[i+1];
      assign r_flags = flag_w[i+1];
    end

    stst_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .item        (item),
      .left_entry  (l_entry),
      .left_flags  (l_flags),
      .right_entry (r_entry),
      .right_flags (r_flags),
      .entry       (entry_w[i]),
      .flags       (flag_w[i])
    );

    assign eq_vec[i] = flag_w[i].eq;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      stst_pkg::CTL_IDLE: begin
        if (accept) state_next = stst_pkg::CTL_COMPARE;
      end
      stst_pkg::CTL_COMPARE: begin
        state_next = stst_pkg::CTL_COMMIT;
      end
      stst_pkg::CTL_COMMIT: begin
        if (accept) state_next = stst_pkg::CTL_COMPARE;
        else if (commit) state_next = stst_pkg::CTL_IDLE;
      end
      default: state_next = stst_pkg::CTL_IDLE;
    endcase
  end

  // Outputs of the control
  always_comb begin
    s_tready     = 1'b0;
    ctrl.compare = 1'b0;
    ctrl.insert  = 1'b0;
    ctrl.remove  = 1'b0;
    unique case (state)
      stst_pkg::CTL_IDLE: begin
        s_tready = 1'b1;
      end
      stst_pkg::CTL_COMPARE: begin
        ctrl.compare = 1'b1;
      end
      stst_pkg::CTL_COMMIT: begin
        s_tready    = out_free;
        ctrl.insert = commit && (kind == stst_pkg::KIND_INSERT) && !full;
        ctrl.remove = commit && (kind == stst_pkg::KIND_REMOVE) && found;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (ctrl.insert) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    priority if (kind == stst_pkg::KIND_INSERT) begin
      status_next = full ? stst_pkg::ST_FULL : stst_pkg::ST_INSERTED;
    end else begin
      status_next = found ? stst_pkg::ST_REMOVED : stst_pkg::ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= stst_pkg::CTL_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Hold the accepted word for the compare and shift cycles
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= stst_pkg::value_t'(s_tdata);
      kind <= stst_pkg::kind_t'(s_tuser);
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status_q  <= status_next;
      removed_q <= ctrl.remove ? item : '0;
      stored_q  <= stst_pkg::OUTCNT_W'(count_next);
    end
  end

  assign m_tdata = {3'b000, stored_q, removed_q};
  assign m_tuser = status_q;

endmodule

FILE: dv/tb_sorted_table_insert_remove_unit.sv
// Testbench for sorted_table_insert_remove_unit: directed rows, then biased random inserts/removes.
// Result words are checked against a typed row's expected value, else a behavioral table model.
// Depends on stst_pkg and the RTL of the unit.
module tb_sorted_table_insert_remove_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP         = 16;
  localparam int RAND_PHASES = 13;
  localparam int PHASE_WORDS = 100;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    stst_pkg::status_t status;
    stst_pkg::value_t  removed;
    logic [4:0]        count;
  } table_result_t;

  typedef struct {
    stst_pkg::kind_t  kind;
    stst_pkg::value_t value;
    bit               typed;
    table_result_t    want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  // Model of the table contents, in ascending order
  stst_pkg::value_t held_vals [CAP];
  int               held_cnt = 0;
  table_result_t    pending_results [$];

  int err_cnt  = 0;
  int idle_cyc = 0;
  bit quiet    = 1'b0;
  int n_insert = 0;
  int n_remove = 0;
  int n_full   = 0;
  int n_absent = 0;
  int n_words  = 0;

  sorted_table_insert_remove_unit #(.CAPACITY(CAP)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic table_result_t apply_table_op(input stst_pkg::kind_t k,
                                                   input stst_pkg::value_t v);
    table_result_t r;
    int            pos;
    int            i;
    r.status  = stst_pkg::ST_INSERTED;
    r.removed = '0;
    pos = held_cnt;
    if (k == stst_pkg::KIND_INSERT) begin
      if (held_cnt >= CAP) begin
        r.status = stst_pkg::ST_FULL;
      end else begin
        // place after all equal entries
        for (i = held_cnt - 1; i >= 0; i--) begin
          if (held_vals[i] > v) pos = i;
        end
        for (i = held_cnt; i > pos; i--) held_vals[i] = held_vals[i-1];
        held_vals[pos] = v;
        held_cnt++;
      end
    end else begin
      for (i = held_cnt - 1; i >= 0; i--) begin
        if (held_vals[i] == v) pos = i;
      end
      if (pos >= held_cnt) begin
        r.status = stst_pkg::ST_NOT_FOUND;
      end else begin
        r.status  = stst_pkg::ST_REMOVED;
        r.removed = held_vals[pos];
        for (i = pos; i + 1 < held_cnt; i++) held_vals[i] = held_vals[i+1];
        held_cnt--;
      end
    end
    r.count = held_cnt[4:0];
    return r;
  endfunction

  function automatic int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Often from a small pool so removes hit and duplicates pile up
  function automatic stst_pkg::value_t draw_value();
    unique case ($urandom_range(0, 9))
      0, 1, 2, 3: return stst_pkg::value_t'((int'($urandom_range(0, 6)) - 3) * 65536);
      4: begin
        unique case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh0000_0000;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return stst_pkg::value_t'($urandom);
    endcase
  endfunction

  task automatic send_word(input stst_pkg::kind_t k, input stst_pkg::value_t v,
                           input bit typed, input table_result_t want);
    int            gap;
    table_result_t r;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= k;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = apply_table_op(k, v);
    unique case (r.status)
      stst_pkg::ST_INSERTED:  n_insert++;
      stst_pkg::ST_REMOVED:   n_remove++;
      stst_pkg::ST_FULL:      n_full++;
      stst_pkg::ST_NOT_FOUND: n_absent++;
      default: ;
    endcase
    n_words++;
    pending_results.push_back(typed ? want : r);
  endtask

  // Hold the sender until every outstanding result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    table_result_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: status %0d count %0d",
               m_tuser, m_tdata[36:32]);
        err_cnt++;
      end else begin
        w = pending_results.pop_front();
        if (m_tuser != w.status) begin
          $error("status: expected %0d, got %0d", w.status, m_tuser);
          err_cnt++;
        end
        if (m_tdata[31:0] != w.removed) begin
          $error("removed_value: expected %h, got %h", w.removed, m_tdata[31:0]);
          err_cnt++;
        end
        if (m_tdata[36:32] != w.count) begin
          $error("stored_count: expected %0d, got %0d", w.count, m_tdata[36:32]);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= STALL_LIMIT) begin
      $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  // Receiver: random stall before each result word
  initial begin
    int stall;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    dir_row_t         dir_rows [$];
    table_result_t    none;
    stst_pkg::kind_t  k;
    stst_pkg::value_t v;
    int               ins_pct;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = stst_pkg::KIND_INSERT;
    none     = '{stst_pkg::ST_INSERTED, 32'sd0, 5'd0};

    // kind, value, typed, {status, removed_value, stored_count}
    dir_rows.push_back('{stst_pkg::KIND_REMOVE, 32'sh0000_0000, 1'b1,
                         '{stst_pkg::ST_NOT_FOUND, 32'sh0, 5'd0}});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 1'b1,
                         '{stst_pkg::ST_INSERTED, 32'sh0, 5'd1}});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh8000_0000, 1'b1,
                         '{stst_pkg::ST_INSERTED, 32'sh0, 5'd2}});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh0000_0000, 1'b1,
                         '{stst_pkg::ST_INSERTED, 32'sh0, 5'd3}});
    dir_rows.push_back('{stst_pkg::KIND_REMOVE, 32'sh8000_0000, 1'b1,
                         '{stst_pkg::ST_REMOVED, 32'sh8000_0000, 5'd2}});
    dir_rows.push_back('{stst_pkg::KIND_REMOVE, 32'sh0005_0000, 1'b1,
                         '{stst_pkg::ST_NOT_FOUND, 32'sh0, 5'd2}});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh0000_0000, 1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh0000_0000, 1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_REMOVE, 32'sh0000_0000, 1'b1,
                         '{stst_pkg::ST_REMOVED, 32'sh0, 5'd3}});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, -32'sd1,        1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh0000_0001, 1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh0001_0000, 1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh4000_0000, 1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'shC000_0000, 1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh8000_0000, 1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh0000_8000, 1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'shFFFF_8000, 1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh1234_5678, 1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'shEDCB_A987, 1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh0000_0001, 1'b0, none});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'shFFFF_FFFE, 1'b1,
                         '{stst_pkg::ST_INSERTED, 32'sh0, 5'd16}});
    dir_rows.push_back('{stst_pkg::KIND_INSERT, 32'sh0000_0000, 1'b1,
                         '{stst_pkg::ST_FULL, 32'sh0, 5'd16}});
    dir_rows.push_back('{stst_pkg::KIND_REMOVE, 32'sh7FFF_FFFF, 1'b1,
                         '{stst_pkg::ST_REMOVED, 32'sh7FFF_FFFF, 5'd15}});
    dir_rows.push_back('{stst_pkg::KIND_REMOVE, -32'sd1,        1'b0, none});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_word(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    // Each phase leans toward filling, emptying or churning the table
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      unique case (ph % 4)
        0: ins_pct = 85;
        1: ins_pct = 50;
        2: ins_pct = 15;
        default: ins_pct = 60;
      endcase
      quiet = (ph % 4 == 3);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        k = ($urandom_range(0, 99) < ins_pct) ? stst_pkg::KIND_INSERT
                                               : stst_pkg::KIND_REMOVE;
        v = draw_value();
        // removes mostly target a held entry
        if (k == stst_pkg::KIND_REMOVE && held_cnt > 0 && $urandom_range(0, 9) < 6)
          v = held_vals[$urandom_range(0, held_cnt - 1)];
        send_word(k, v, 1'b0, none);
      end
      if (ph % 3 == 2) drain_results();
    end
    quiet = 1'b0;

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("%0d words: %0d inserted, %0d removed, %0d rejected full, %0d not found",
             n_words, n_insert, n_remove, n_full, n_absent);
    $display("table driven from empty to full and back under random stalls on both sides");
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/stst_pkg.sv
rtl/core/stst_cell.sv
rtl/core/sorted_table_insert_remove_unit.sv
dv/tb_sorted_table_insert_remove_unit.sv
